FILE: design/tbcm_pkg.sv
// Shared types, constants and codes of the token bucket color meter.
package tbcm_pkg;

  localparam int NUM_METERS     = 1024;
  localparam int RATE_FRAC_BITS = 16;

  localparam int CMD_W    = 2;
  localparam int SEL_W    = 2;
  localparam int IDX_W    = 10;
  localparam int TIME_W   = 48;
  localparam int VAL_W    = 32;
  localparam int COLOR_W  = 2;
  localparam int COUNT_W  = 64;
  localparam int NUM_CNT  = 3;

  localparam int MEM_DEPTH = (NUM_METERS < (1 << IDX_W)) ? NUM_METERS : (1 << IDX_W);
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int DVD_W  = VAL_W + RATE_FRAC_BITS;
  localparam int OPA_W  = (TIME_W > DVD_W) ? TIME_W : DVD_W;
  localparam int PROD_W = OPA_W + VAL_W;
  localparam int STEP_W = $clog2(OPA_W + 1);

  localparam logic [CMD_W-1:0] CMD_EXEC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  localparam logic [SEL_W-1:0] SEL_YELLOW = 2'd1;
  localparam logic [SEL_W-1:0] SEL_RED    = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd0;

  typedef struct packed {
    logic              valid;
    logic [VAL_W-1:0]  rate;
    logic [VAL_W-1:0]  burst;
    logic [VAL_W-1:0]  tokens;
    logic [TIME_W-1:0] last;
  } bucket_t;

  localparam int BKT_W = $bits(bucket_t);

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [OPA_W-1:0] opa;
    logic [VAL_W-1:0] opb;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] result;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECODE,
    ST_LOAD,
    ST_MUL,
    ST_REFILL,
    ST_DIV,
    ST_CHARGE,
    ST_COUNT
  } state_t;

endpackage

FILE: design/token_bucket_color_meter_unit.sv
// Top level of the two-bucket token meter with per-color packet counters.
// Set, reset and unused commands go from accept through ST_READ and ST_DECODE to the result.
// Execute goes through ST_READ, ST_DECODE and, per bucket, ST_LOAD; a valid bucket also runs the 32-step multiply
// and, when tokens are added, the 32+RATE_FRAC_BITS-step divide, then ST_CHARGE, ending in ST_COUNT.
// One item at a time; the next is taken once the result has been delivered.
// After reset a clearing pass over all MEM_DEPTH entries zeroes all tables before items are taken.
module token_bucket_color_meter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // index[9:0], timestamp[57:10], amount[89:58], rate[121:90], burst[153:122], zero pad
  input  logic [159:0] in_tdata,
  // command[1:0], bucket_select[3:2]
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // color_count[63:0]
  output logic [63:0]  out_tdata,
  // color[1:0]
  output logic [1:0]   out_tuser
);
  import tbcm_pkg::*;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [TIME_W-1:0]  ts_r, ts_nxt;
  logic [VAL_W-1:0]   amt_r, amt_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic [VAL_W-1:0]   rate_r, rate_nxt;
  logic [VAL_W-1:0]   burst_r, burst_nxt;
  logic               k_r, k_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  bucket_t            cur_r, cur_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               bkt_we [2];
  bucket_t            bkt_wdata [2];
  bucket_t            bkt_rdata [2];
  logic               cnt_we [NUM_CNT];
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cnt_rdata [NUM_CNT];
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  idx_addr;

  arith_req_t         areq;
  arith_rsp_t         arsp;

  logic               accept;
  logic               sat;
  logic [VAL_W-1:0]   add_amt;
  logic [VAL_W:0]     sum;
  logic [VAL_W-1:0]   tok_sat;
  logic [COUNT_W-1:0] cnt_inc;

  assign idx_addr  = idx_r[ADDR_W-1:0];
  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign accept    = in_tvalid && in_tready;

  assign sat     = |arsp.result[PROD_W-1:VAL_W+RATE_FRAC_BITS];
  assign add_amt = sat ? '1 : arsp.result[VAL_W+RATE_FRAC_BITS-1:RATE_FRAC_BITS];
  assign sum     = {1'b0, cur_r.tokens} + {1'b0, add_amt};
  assign tok_sat = sum[VAL_W] ? '1 : sum[VAL_W-1:0];
  assign cnt_inc = cnt_rdata[color_r] + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    ts_nxt        = ts_r;
    amt_nxt       = amt_r;
    sel_nxt       = sel_r;
    rate_nxt      = rate_r;
    burst_nxt     = burst_r;
    k_nxt         = k_r;
    color_nxt     = color_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_color_nxt = out_color_r;
    out_count_nxt = out_count_r;
    waddr         = idx_addr;
    bkt_we[0]     = 1'b0;
    bkt_we[1]     = 1'b0;
    bkt_wdata[0]  = '0;
    bkt_wdata[1]  = '0;
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_we[i] = 1'b0;
    end
    cnt_wdata   = '0;
    areq.start  = 1'b0;
    areq.is_div = 1'b0;
    areq.opa    = OPA_W'(ts_r - cur_r.last);
    areq.opb    = cur_r.rate;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        waddr     = clr_r;
        bkt_we[0] = 1'b1;
        bkt_we[1] = 1'b1;
        for (int i = 0; i < NUM_CNT; i++) begin
          cnt_we[i] = 1'b1;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_tuser[1:0];
          sel_nxt   = in_tuser[3:2];
          idx_nxt   = in_tdata[9:0];
          ts_nxt    = in_tdata[57:10];
          amt_nxt   = in_tdata[89:58];
          rate_nxt  = in_tdata[121:90];
          burst_nxt = in_tdata[153:122];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        out_color_nxt = COLOR_GREEN;
        out_count_nxt = '0;
        state_nxt     = ST_IDLE;
        if (32'(idx_r) >= 32'(NUM_METERS)) begin
          out_valid_nxt = 1'b1;
        end else if (cmd_r == CMD_EXEC) begin
          k_nxt     = 1'b0;
          color_nxt = COLOR_GREEN;
          state_nxt = ST_LOAD;
        end else begin
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_SET) begin
            bkt_wdata[0] = '{valid: 1'b1, rate: rate_r, burst: burst_r,
                             tokens: burst_r, last: '0};
            bkt_wdata[1] = bkt_wdata[0];
            bkt_we[0]    = (sel_r == SEL_YELLOW);
            bkt_we[1]    = (sel_r == SEL_RED);
          end else if (cmd_r == CMD_RESET) begin
            bkt_we[0] = 1'b1;
            bkt_we[1] = 1'b1;
            for (int i = 0; i < NUM_CNT; i++) begin
              cnt_we[i] = 1'b1;
            end
          end
        end
      end
      ST_LOAD: begin
        cur_nxt = bkt_rdata[k_r];
        if (!bkt_rdata[k_r].valid) begin
          if (k_r) begin
            state_nxt = ST_COUNT;
          end else begin
            k_nxt = 1'b1;
          end
        end else begin
          areq.start = 1'b1;
          areq.opa   = OPA_W'(ts_r - bkt_rdata[k_r].last);
          areq.opb   = bkt_rdata[k_r].rate;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        if (arsp.done) begin
          state_nxt = ST_REFILL;
        end
      end
      ST_REFILL: begin
        if ((add_amt != '0) && (cur_r.rate != '0)) begin
          cur_nxt.tokens = (tok_sat > cur_r.burst) ? cur_r.burst : tok_sat;
          areq.start     = 1'b1;
          areq.is_div    = 1'b1;
          areq.opa       = OPA_W'({add_amt, {RATE_FRAC_BITS{1'b0}}});
          areq.opb       = cur_r.rate;
          state_nxt      = ST_DIV;
        end else begin
          state_nxt = ST_CHARGE;
        end
      end
      ST_DIV: begin
        if (arsp.done) begin
          cur_nxt.last = cur_r.last + arsp.result[TIME_W-1:0];
          state_nxt    = ST_CHARGE;
        end
      end
      ST_CHARGE: begin
        bkt_we[k_r]    = 1'b1;
        bkt_wdata[k_r] = cur_r;
        if (cur_r.tokens < amt_r) begin
          color_nxt = COLOR_W'({1'b0, k_r} + 2'd1);
          if (k_r) begin
            state_nxt = ST_COUNT;
          end else begin
            k_nxt     = 1'b1;
            state_nxt = ST_LOAD;
          end
        end else begin
          bkt_wdata[k_r].tokens = cur_r.tokens - amt_r;
          state_nxt             = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cnt_we[color_r] = 1'b1;
        cnt_wdata       = cnt_inc;
        out_valid_nxt   = 1'b1;
        out_color_nxt   = color_r;
        out_count_nxt   = cnt_inc;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    ts_r        <= ts_nxt;
    amt_r       <= amt_nxt;
    sel_r       <= sel_nxt;
    rate_r      <= rate_nxt;
    burst_r     <= burst_nxt;
    k_r         <= k_nxt;
    color_r     <= color_nxt;
    cur_r       <= cur_nxt;
    out_color_r <= out_color_nxt;
    out_count_r <= out_count_nxt;
  end

  for (genvar g = 0; g < 2; g++) begin : g_bkt
    tbcm_ram #(.W(BKT_W), .D(MEM_DEPTH)) u_bkt_ram (
      .clk   (clk),
      .we    (bkt_we[g]),
      .waddr (waddr),
      .wdata (bkt_wdata[g]),
      .raddr (idx_addr),
      .rdata (bkt_rdata[g])
    );
  end

  for (genvar g = 0; g < NUM_CNT; g++) begin : g_cnt
    tbcm_ram #(.W(COUNT_W), .D(MEM_DEPTH)) u_cnt_ram (
      .clk   (clk),
      .we    (cnt_we[g]),
      .waddr (waddr),
      .wdata (cnt_wdata),
      .raddr (idx_addr),
      .rdata (cnt_rdata[g])
    );
  end

  tbcm_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .rsp   (arsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_color_r;

endmodule

FILE: design/tbcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tbcm_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                        wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/tbcm_arith.sv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
module tbcm_arith (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tbcm_pkg::arith_req_t   req,
  output tbcm_pkg::arith_rsp_t   rsp
);
  import tbcm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              is_div_r, is_div_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [OPA_W-1:0]  a_r, a_nxt;
  logic [VAL_W-1:0]  b_r, b_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [OPA_W-1:0]  qr_r, qr_nxt;
  logic [VAL_W-1:0]  rem_r, rem_nxt;
  logic [VAL_W:0]    trial;
  logic [STEP_W-1:0] last_step;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    is_div_nxt = is_div_r;
    step_nxt   = step_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    qr_nxt     = qr_r;
    rem_nxt    = rem_r;
    trial      = {rem_r, qr_r[OPA_W-1]};
    last_step  = is_div_r ? STEP_W'(OPA_W - 1) : STEP_W'(VAL_W - 1);
    if (req.start) begin
      busy_nxt   = 1'b1;
      is_div_nxt = req.is_div;
      step_nxt   = '0;
      a_nxt      = req.opa;
      b_nxt      = req.opb;
      acc_nxt    = '0;
      qr_nxt     = req.opa;
      rem_nxt    = '0;
    end else if (busy_r) begin
      if (is_div_r) begin
        if (trial >= {1'b0, b_r}) begin
          rem_nxt = VAL_W'(trial - {1'b0, b_r});
          qr_nxt  = {qr_r[OPA_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[VAL_W-1:0];
          qr_nxt  = {qr_r[OPA_W-2:0], 1'b0};
        end
      end else begin
        acc_nxt = {acc_r[PROD_W-2:0], 1'b0} + (b_r[VAL_W-1] ? PROD_W'(a_r) : '0);
        b_nxt   = {b_r[VAL_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == last_step) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    is_div_r <= is_div_nxt;
    step_r   <= step_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    qr_r     <= qr_nxt;
    rem_r    <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = is_div_r ? PROD_W'(qr_r) : acc_r;

endmodule
